// ===== src/fit_strategy_block_allocator_core_assert.svh =====
// Assertion macros for the fit-strategy block allocator.
`ifndef FIT_STRATEGY_BLOCK_ALLOCATOR_CORE_ASSERT_SVH
`define FIT_STRATEGY_BLOCK_ALLOCATOR_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define FSBA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define FSBA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define FSBA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define FSBA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== src/fsba_pkg.sv =====
// Shared constants for the fit-strategy block allocator.
package fsba_pkg;

    localparam int IDX_W      = 5;
    localparam int STRAT_W    = 2;
    localparam int COUNT_W    = 6;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [STRAT_W-1:0] FIT_FIRST = 2'd0;
    localparam logic [STRAT_W-1:0] FIT_WORST = 2'd1;
    localparam logic [STRAT_W-1:0] FIT_BEST  = 2'd2;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_ALLOC = 1'b1;

    localparam logic REG_STRATEGY = 1'b0;
    localparam logic REG_COUNT    = 1'b1;

endpackage

// ===== src/fsba_if.sv =====
// Request and response channel interfaces of the block allocator.
interface fsba_req_if #(
    parameter int SIZE_BITS = 16
);
    import fsba_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 cmd;
    logic [IDX_W-1:0]     block_index;
    logic [SIZE_BITS-1:0] block_size;
    logic [SIZE_BITS-1:0] request_size;

    modport source (output valid, cmd, block_index, block_size, request_size, input ready);
    modport sink   (input valid, cmd, block_index, block_size, request_size, output ready);
endinterface

interface fsba_rsp_if #(
    parameter int SIZE_BITS = 16
);
    import fsba_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 allocated;
    logic [IDX_W-1:0]     chosen_block;
    logic [SIZE_BITS-1:0] chosen_size;
    logic [SIZE_BITS-1:0] leftover;

    modport source (output valid, allocated, chosen_block, chosen_size, leftover, input ready);
    modport sink   (input valid, allocated, chosen_block, chosen_size, leftover, output ready);
endinterface

// ===== src/fsba_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module fsba_ram #(
    parameter  int WIDTH  = 17,
    parameter  int DEPTH  = 32,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

// ===== src/fit_strategy_block_allocator_core.sv =====
// Fit-strategy block allocator: size table scan with first, worst and best fit.
// A load request writes its table entry, if its index is below BLOCKS, as it is taken. An
// allocate request scans the first block_count entries (block_count capped at BLOCKS) and
// posts its response from the done state, after which the next request is taken; a response
// still waiting stalls the final step. After reset the table RAM is cleared, one entry per
// cycle, while no request is taken; configuration writes are taken throughout.
module fit_strategy_block_allocator_core #(
    parameter int BLOCKS    = 32,
    parameter int SIZE_BITS = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    fsba_req_if.sink                         i_req,
    fsba_rsp_if.source                       o_rsp,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [fsba_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [fsba_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [fsba_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready
);
    import fsba_pkg::*;

    `include "fit_strategy_block_allocator_core_assert.svh"

    localparam int ADDR_W = (BLOCKS > 1) ? $clog2(BLOCKS) : 1;
    localparam int CNT_W  = $clog2(BLOCKS + 1);
    localparam int WORD_W = SIZE_BITS + 1;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } t_state;

    t_state               r_state;
    logic [STRAT_W-1:0]   r_strategy;
    logic [COUNT_W-1:0]   r_block_count;
    logic [ADDR_W-1:0]    r_clr_ptr;
    logic [CNT_W-1:0]     r_ptr;
    logic [CNT_W-1:0]     r_limit;
    logic                 r_rd_valid;
    logic [ADDR_W-1:0]    r_rd_idx;
    logic [SIZE_BITS-1:0] r_req;
    logic                 r_found;
    logic [ADDR_W-1:0]    r_pick;
    logic [SIZE_BITS-1:0] r_pick_size;
    logic [SIZE_BITS-1:0] r_best;
    logic                 r_out_valid;
    logic                 r_out_alloc;
    logic [IDX_W-1:0]     r_out_block;
    logic [SIZE_BITS-1:0] r_out_size;
    logic [SIZE_BITS-1:0] r_out_left;

    logic                 cfg_wr;
    logic                 req_fire;
    logic                 load_in_range;
    logic [ADDR_W-1:0]    load_addr;
    logic [ADDR_W+IDX_W-1:0] load_wide;
    logic [ADDR_W+IDX_W-1:0] pick_wide;
    logic [31:0]          limit_full;
    logic                 slot_free;
    logic                 wr_en;
    logic [ADDR_W-1:0]    wr_addr;
    logic [WORD_W-1:0]    wr_data;
    logic                 rd_en;
    logic [WORD_W-1:0]    rd_data;
    logic                 ent_used;
    logic [SIZE_BITS-1:0] ent_size;
    logic [SIZE_BITS-1:0] ent_left;
    logic                 ent_fits;
    logic                 ent_take;
    logic [CNT_W-1:0]     pick_cnt;

    // Configuration port.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[2] == REG_COUNT) ? APB_DATA_W'(r_block_count)
                                            : APB_DATA_W'(r_strategy);

    assign i_req.ready   = (r_state == ST_IDLE);
    assign req_fire      = i_req.valid && i_req.ready;
    assign load_in_range = (32'(i_req.block_index) < BLOCKS);
    assign load_wide     = {{ADDR_W{1'b0}}, i_req.block_index};
    assign load_addr     = load_wide[ADDR_W-1:0];
    assign pick_wide     = {{IDX_W{1'b0}}, r_pick};
    assign pick_cnt      = CNT_W'(r_pick);
    assign limit_full    = (32'(r_block_count) > BLOCKS) ? BLOCKS : 32'(r_block_count);
    assign slot_free     = !r_out_valid || o_rsp.ready;

    // Evaluate the entry that came back from the table RAM.
    assign ent_used = rd_data[SIZE_BITS];
    assign ent_size = rd_data[SIZE_BITS-1:0];
    assign ent_left = ent_size - r_req;
    assign ent_fits = !ent_used && (ent_size >= r_req);

    always_comb begin
        ent_take = 1'b0;
        if (r_rd_valid && ent_fits) begin
            if (!r_found) begin
                ent_take = 1'b1;
            end else if (r_strategy == FIT_WORST) begin
                ent_take = (ent_left > r_best);
            end else if (r_strategy == FIT_BEST) begin
                ent_take = (ent_left < r_best);
            end
        end
    end

    assign rd_en = (r_state == ST_SCAN) && (r_ptr < r_limit);

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_clr_ptr;
        wr_data = '0;
        case (r_state)
            ST_CLEAR: begin
                wr_en = 1'b1;
            end
            ST_IDLE: begin
                if (req_fire && i_req.cmd == CMD_LOAD && load_in_range) begin
                    wr_en   = 1'b1;
                    wr_addr = load_addr;
                    wr_data = {1'b0, i_req.block_size};
                end
            end
            ST_DONE: begin
                if (slot_free && r_found) begin
                    wr_en   = 1'b1;
                    wr_addr = r_pick;
                    wr_data = {1'b1, r_pick_size};
                end
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    fsba_ram #(
        .WIDTH (WORD_W),
        .DEPTH (BLOCKS)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_ptr[ADDR_W-1:0]),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_CLEAR;
            r_strategy    <= FIT_FIRST;
            r_block_count <= '0;
            r_clr_ptr     <= '0;
            r_rd_valid    <= 1'b0;
            r_found       <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (cfg_wr) begin
                if (paddr[2] == REG_STRATEGY) begin
                    r_strategy <= pwdata[STRAT_W-1:0];
                end else begin
                    r_block_count <= pwdata[COUNT_W-1:0];
                end
            end

            // A response posted from the done state replaces the one that leaves.
            if (r_out_valid && o_rsp.ready && r_state != ST_DONE) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                ST_CLEAR: begin
                    r_clr_ptr <= r_clr_ptr + 1'b1;
                    if (r_clr_ptr == ADDR_W'(BLOCKS - 1)) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (req_fire && i_req.cmd == CMD_ALLOC) begin
                        r_req      <= i_req.request_size;
                        r_limit    <= CNT_W'(limit_full);
                        r_ptr      <= '0;
                        r_found    <= 1'b0;
                        r_rd_valid <= 1'b0;
                        r_state    <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    r_rd_valid <= rd_en;
                    r_rd_idx   <= r_ptr[ADDR_W-1:0];
                    if (rd_en) begin
                        r_ptr <= r_ptr + 1'b1;
                    end
                    if (ent_take) begin
                        r_found     <= 1'b1;
                        r_pick      <= r_rd_idx;
                        r_pick_size <= ent_size;
                        r_best      <= ent_left;
                    end
                    // Finished once every entry has been issued and the last read evaluated.
                    if (!rd_en && !r_rd_valid) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (slot_free) begin
                        r_out_valid <= 1'b1;
                        r_out_alloc <= r_found;
                        if (r_found) begin
                            r_out_block <= pick_wide[IDX_W-1:0];
                            r_out_size  <= r_pick_size;
                            r_out_left  <= r_best;
                        end else begin
                            r_out_block <= '0;
                            r_out_size  <= '0;
                            r_out_left  <= '0;
                        end
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.allocated    = r_out_alloc;
    assign o_rsp.chosen_block = r_out_block;
    assign o_rsp.chosen_size  = r_out_size;
    assign o_rsp.leftover     = r_out_left;

    `FSBA_ASSERT_IMP(a_pick_in_range, i_clk, i_rst_n, r_state == ST_DONE && r_found, pick_cnt < r_limit, "chosen block lies outside the scanned range")
    `FSBA_ASSERT_IMP(a_scan_ptr_bound, i_clk, i_rst_n, r_state == ST_SCAN, r_ptr <= r_limit, "scan pointer ran past the limit")
    `FSBA_ASSERT_IMP(a_read_in_scan, i_clk, i_rst_n, r_rd_valid, r_state == ST_SCAN, "table read returned outside a scan")
    `FSBA_ASSERT_IMP(a_miss_zero, i_clk, i_rst_n, r_out_valid && !r_out_alloc, r_out_block == '0 && r_out_size == '0 && r_out_left == '0, "a miss carries nonzero fields")
    `FSBA_ASSERT_NEXT(a_done_leaves, i_clk, i_rst_n, r_state == ST_DONE && slot_free, r_state == ST_IDLE && r_out_valid, "finished allocation did not post its response")
endmodule
